>>> design/htd_pkg.sv
package htd_pkg;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int DATA_W = 40;

  // command codes carried in s_tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // one access cycle of the node store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CUR   = 3'b010,
    S_CHILD = 3'b100
  } state_t;

endpackage

>>> design/htd_node_ram.sv
module htd_node_ram import htd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic     clk,
  input  ram_req_t req,
  output node_t    rdata
);

  // indices are 9 bits wide, so at most 512 entries are reachable
  localparam int DEPTH = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(DEPTH);

  node_t mem [DEPTH];
  node_t rd_q;
  logic  rd_oob;

  logic w_in_range;
  logic r_in_range;

  assign w_in_range = {1'b0, req.waddr} < LIMIT;
  assign r_in_range = {1'b0, req.raddr} < LIMIT;

  always_ff @(posedge clk) begin
    if (req.we && w_in_range) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_oob <= !r_in_range;
      if (r_in_range) begin
        rd_q <= mem[req.raddr[AW-1:0]];
      end
    end
  end

  // an index beyond the store reads as an all-zero node
  assign rdata = rd_oob ? '0 : rd_q;

endmodule

>>> design/huffman_tree_decoder.sv
// huffman tree-walk decoder
//
// input stream (s_*): one beat is one command, selected by s_tuser
//   node write: stores leaf flag, symbol and both child indices at node_index,
//     accepted without leaving the idle state, no result
//   decode: steps from the current node by bit_value (0 left, 1 right); when
//     the child is a leaf its symbol leaves on m_tdata and the walk returns
//     to the root
// output stream (m_*): one beat per decoded symbol, held in an output register
// config channel (cfg_*): writes root_index; a walk picks it up as it ends
//   at a leaf or the first decode after reset; a running walk is not moved
// decode steps: a beat reads only the child (S_CHILD) when the current node is
//   already held in the node register, and first the current node (S_CUR)
//   when it must be read from the node store (first bit of every symbol, or
//   after any node write); reads are registered, s_tready is low meanwhile
// emit: a symbol appears on m_tvalid the cycle after the child step that loads it
// reset: walk goes back to the start state, root is 0, output empty; the node
//   store is not cleared and must be written before it is walked
// stall: a finished symbol waits in the output register while the next beat
//   is taken; a decode that reaches another leaf waits until the register frees
module huffman_tree_decoder import htd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic              clk,
  input  logic              rst,
  // s_tdata from bit 0: node_index[8:0], node_is_leaf, node_symbol[7:0],
  // node_left[8:0], node_right[8:0], bit_value, zero fill
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  // s_tuser: command (0 node write, 1 decode)
  input  logic              s_tuser,
  // m_tdata: symbol[7:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [SYM_W-1:0]  m_tdata,
  // cfg_data: root_index[8:0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] root;
  logic [IDX_W-1:0] walk_pos;
  logic             walk_started;
  node_t            cur;        // copy of the node at walk_pos
  logic             cur_valid;
  logic             bit_q;
  logic [IDX_W-1:0] next_idx;
  logic [SYM_W-1:0] out_sym;
  logic             out_valid;

  ram_req_t req;
  node_t    rdata;

  // input beat fields
  logic [IDX_W-1:0] in_index;
  node_t            in_node;
  logic             in_bit;
  logic             accept;
  logic             out_free;
  logic [IDX_W-1:0] start_pos;
  logic [IDX_W-1:0] cur_child;
  logic [IDX_W-1:0] rd_child;

  assign in_index      = s_tdata[8:0];
  assign in_node.leaf  = s_tdata[9];
  assign in_node.sym   = s_tdata[17:10];
  assign in_node.left  = s_tdata[26:18];
  assign in_node.right = s_tdata[35:27];
  assign in_bit        = s_tdata[36];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_sym;
  assign out_free  = !out_valid || m_tready;

  // first decode after reset starts from the root
  assign start_pos = walk_started ? walk_pos : root;
  assign cur_child = in_bit ? cur.right : cur.left;
  assign rd_child  = bit_q ? rdata.right : rdata.left;

  htd_node_ram #(
    .NODE_COUNT(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // store access and next state
  always_comb begin
    req        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_WRITE) begin
            req.we    = 1'b1;
            req.waddr = in_index;
            req.wdata = in_node;
          end else if (cur_valid) begin
            // node already held: go straight to the child
            req.re     = 1'b1;
            req.raddr  = cur_child;
            state_next = S_CHILD;
          end else begin
            req.re     = 1'b1;
            req.raddr  = start_pos;
            state_next = S_CUR;
          end
        end
      end
      S_CUR: begin
        req.re     = 1'b1;
        req.raddr  = rd_child;
        state_next = S_CHILD;
      end
      S_CHILD: begin
        // a leaf waits here until the output register frees up
        if (!rdata.leaf || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root         <= '0;
      walk_pos     <= '0;
      walk_started <= 1'b0;
      cur_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        root <= cfg_data;
      end
      // a new symbol loads as the old one leaves, else the register drains
      if (state == S_CHILD && rdata.leaf && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_WRITE) begin
              // any write may change the held node
              cur_valid <= 1'b0;
            end else begin
              bit_q        <= in_bit;
              walk_pos     <= start_pos;
              walk_started <= 1'b1;
              next_idx     <= cur_child;
            end
          end
        end
        S_CUR: begin
          next_idx <= rd_child;
        end
        S_CHILD: begin
          if (!rdata.leaf) begin
            walk_pos  <= next_idx;
            cur       <= rdata;
            cur_valid <= 1'b1;
          end else if (out_free) begin
            out_sym   <= rdata.sym;
            walk_pos  <= root;
            cur_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a decode never completes in the cycle it is taken
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == CMD_DECODE |=> !s_tready)
    else $error("decode beat finished in its accept cycle");

  // a leaf blocked by a full output register keeps waiting
  assert property (@(posedge clk) disable iff (rst)
    state == S_CHILD && rdata.leaf && out_valid && !m_tready |=> state == S_CHILD)
    else $error("leaf left while output register full");

  // a new symbol only comes from the child step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_CHILD))
    else $error("symbol emitted outside child step");

  // the held node only exists inside a started walk
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> walk_started)
    else $error("node register valid before walk start");
`endif

endmodule

>>> tb/huffman_tree_decoder_tb.sv
`timescale 1ns / 1ps

module huffman_tree_decoder_tb;
  import htd_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int STALL_LIMIT = 4000;

  // mirror of the node store and the walk, plus the symbols still owed
  class tree_walk_model;
    node_t            nodes[512];
    bit               written[512];
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] root;
    bit               started;
    logic [SYM_W-1:0] pending_symbols[$];
    int               n_writes;
    int               n_decodes;
    int               n_checked;
    int               n_roots;
    int               failures;

    function new();
      pos       = '0;
      root      = '0;
      started   = 0;
      n_writes  = 0;
      n_decodes = 0;
      n_checked = 0;
      n_roots   = 0;
      failures  = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void note_root(logic [IDX_W-1:0] r);
      root = r;
      n_roots++;
    endfunction

    // first store entry that a decode of this bit would read unwritten, else -1
    function int unwritten_on_walk(logic bv);
      logic [IDX_W-1:0] at;
      logic [IDX_W-1:0] nxt;
      at = started ? pos : root;
      if (!written[at]) return int'(at);
      nxt = bv ? nodes[at].right : nodes[at].left;
      if (!written[nxt]) return int'(nxt);
      return -1;
    endfunction

    function void note_beat(logic cmd, logic [IDX_W-1:0] idx, node_t nd, logic bv);
      logic [IDX_W-1:0] nxt;
      if (cmd == CMD_WRITE) begin
        nodes[idx]   = nd;
        written[idx] = 1;
        n_writes++;
      end else begin
        n_decodes++;
        if (!started) begin
          pos     = root;
          started = 1;
        end
        // leaf flag of the current node is ignored, only the child's counts
        nxt = bv ? nodes[pos].right : nodes[pos].left;
        if (nodes[nxt].leaf) begin
          pending_symbols.push_back(nodes[nxt].sym);
          pos = root;
        end else begin
          pos = nxt;
        end
      end
    endfunction

    function void check_symbol(logic [SYM_W-1:0] got);
      logic [SYM_W-1:0] want;
      if (pending_symbols.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: symbol %02h arrived with none expected", $time, got);
      end else begin
        want = pending_symbols.pop_front();
        n_checked++;
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("%0t: symbol mismatch, expected %02h got %02h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  // fields from bit 0: node_index, node_is_leaf, node_symbol, node_left,
  // node_right, bit_value, zero fill
  logic [DATA_W-1:0] s_tdata   = '0;
  // command
  logic              s_tuser   = CMD_WRITE;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  // symbol
  logic [SYM_W-1:0]  m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_data  = '0;

  tree_walk_model sb = new();

  int          burst_left = 0;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  logic [5:0]  rcv_count = '0;
  logic [15:0] stall_pat = 16'hffff;

  always #6 clk = ~clk;

  huffman_tree_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic logic [IDX_W-1:0] rand_idx();
    logic [31:0] r;
    r = $urandom();
    return r[IDX_W-1:0];
  endfunction

  function automatic node_t rand_node();
    logic [31:0] r;
    r = $urandom();
    return r[$bits(node_t)-1:0];
  endfunction

  // one input beat; the sender idles in bursts, valid stays up inside a burst
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx, input node_t nd,
                           input logic bv);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, bv, nd.right, nd.left, nd.sym, nd.leaf, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_beat(cmd, idx, nd, bv);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_node(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] lft,
                           input logic [IDX_W-1:0] rgt);
    node_t       nd;
    logic [31:0] r;
    r        = $urandom();
    nd.leaf  = leaf;
    nd.sym   = sym;
    nd.left  = lft;
    nd.right = rgt;
    send_item(CMD_WRITE, idx, nd, r[0]);
  endtask

  // decode one bit; entries the walk would touch unwritten get filled first
  task automatic decode_bit(input logic bv);
    int          hole;
    logic [31:0] r;
    hole = sb.unwritten_on_walk(bv);
    while (hole >= 0) begin
      r = $urandom();
      send_item(CMD_WRITE, hole[IDX_W-1:0], rand_node(), r[0]);
      hole = sb.unwritten_on_walk(bv);
    end
    send_item(CMD_DECODE, rand_idx(), rand_node(), bv);
  endtask

  // root changes only with nothing in flight
  task automatic write_root(input logic [IDX_W-1:0] r);
    s_tvalid <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.note_root(r);
  endtask

  // random full tree rooted at rt, then whole codes of its leaves with some noise
  task automatic tree_episode(input logic [IDX_W-1:0] rt);
    logic [IDX_W-1:0] node_idx[81];
    bit               is_leaf[81];
    int               lch[81];
    int               rch[81];
    logic [63:0]      code[81];
    int               clen[81];
    bit               taken[512];
    int               leaves[$];
    int               k, count, j, p, side, n, nsym, roll, lf, b;
    logic [IDX_W-1:0] c;
    logic [31:0]      r;
    foreach (taken[i]) taken[i] = 0;
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
    count       = 1;
    node_idx[0] = rt;
    taken[rt]   = 1;
    is_leaf[0]  = 1;
    code[0]     = '0;
    clen[0]     = 0;
    leaves.push_back(0);
    repeat (k - 1) begin
      j = $urandom_range(0, leaves.size() - 1);
      p = leaves[j];
      leaves.delete(j);
      is_leaf[p] = 0;
      for (side = 0; side < 2; side++) begin
        do c = rand_idx(); while (taken[c]);
        taken[c]        = 1;
        node_idx[count] = c;
        is_leaf[count]  = 1;
        code[count]     = {code[p][62:0], side[0]};
        clen[count]     = clen[p] + 1;
        if (side == 0) lch[p] = count;
        else rch[p] = count;
        leaves.push_back(count);
        count++;
      end
    end
    // children go in before their parents
    for (n = count - 1; n >= 0; n--) begin
      r = $urandom();
      if (is_leaf[n])
        send_node(node_idx[n], 1'b1, r[7:0], rand_idx(), rand_idx());
      else
        send_node(node_idx[n], 1'b0, r[7:0], node_idx[lch[n]], node_idx[rch[n]]);
    end
    write_root(rt);
    nsym = $urandom_range(6, 30);
    for (n = 0; n < nsym && beats_sent < ITEM_TARGET; n++) begin
      roll = $urandom_range(0, 99);
      r    = $urandom();
      if (roll < 8) begin
        send_item(CMD_WRITE, rand_idx(), rand_node(), r[0]);
      end else if (roll < 14) begin
        decode_bit(r[1]);
      end else begin
        lf = leaves[$urandom_range(0, leaves.size() - 1)];
        for (b = clen[lf] - 1; b >= 0; b--) decode_bit(code[lf][b]);
      end
    end
  endtask

  // receiver ready follows a 16-bit pattern indexed by the low bits of a 6-bit counter, redrawn when it wraps
  always @(posedge clk) begin : receiver
    logic [31:0] r;
    rcv_count <= rcv_count + 6'd1;
    if (rcv_count == 6'd0) begin
      r = $urandom();
      case ($urandom_range(0, 3))
        0:       stall_pat <= 16'hffff;
        1:       stall_pat <= r[15:0] | 16'h0001;
        2:       stall_pat <= 16'h1111;
        default: stall_pat <= 16'h00ff;
      endcase
    end
    m_tready <= stall_pat[rcv_count[3:0]];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_symbol(m_tdata);
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int ep;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // small tree at root 0, extreme indices and symbols
    send_node(9'd0,   1'b0, 8'h3c, 9'd1,   9'd2);
    send_node(9'd1,   1'b1, 8'h00, 9'd0,   9'd0);
    send_node(9'd2,   1'b0, 8'hff, 9'd3,   9'd511);
    send_node(9'd3,   1'b1, 8'hff, 9'd511, 9'd511);
    send_node(9'd511, 1'b1, 8'ha5, 9'd0,   9'd1);
    // first decode after reset starts at the reset root
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b1);
    // root moved mid-walk: walk finishes from where it was
    decode_bit(1'b1);
    write_root(9'd2);
    decode_bit(1'b0);
    decode_bit(1'b1);
    // root pointing at a leaf node
    write_root(9'd511);
    decode_bit(1'b0);
    decode_bit(1'b0);
    decode_bit(1'b0);
    decode_bit(1'b1);
    // node rewrites while a walk sits on an inner node
    decode_bit(1'b0);
    send_node(9'd4, 1'b1, 8'h5a, 9'd0, 9'd0);
    send_node(9'd2, 1'b0, 8'h00, 9'd4, 9'd3);
    decode_bit(1'b1);
    decode_bit(1'b0);

    ep = 0;
    while (beats_sent < ITEM_TARGET) begin
      if (ep == 0) tree_episode(9'd0);
      else if (ep == 1) tree_episode(9'd511);
      else tree_episode(rand_idx());
      ep++;
    end

    s_tvalid <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d node writes and %0d decode bits over %0d trees, %0d symbols checked",
             sb.n_writes, sb.n_decodes, ep, sb.n_checked);
    $display("root register written %0d times, %0d mismatches, %0d symbols still owed",
             sb.n_roots, sb.failures, sb.pending_symbols.size());
    if (sb.failures == 0 && sb.pending_symbols.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> huffman_tree_decoder.f
design/htd_pkg.sv
design/htd_node_ram.sv
design/huffman_tree_decoder.sv
tb/huffman_tree_decoder_tb.sv
